>>> sv/ntl_pkg.sv
package ntl_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int MAX_OUT = 16;

  typedef enum logic [1:0] {
    CMD_HEARD = 2'd0,
    CMD_POS   = 2'd1,
    CMD_SNAP  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SORT
  } state_t;

  typedef enum logic {
    MODE_LOOKUP,
    MODE_SORT
  } mode_t;

  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic               best_ok;
    logic [31:0]        best_time;
    logic [IDX_W-1:0]   best_pos;
    logic [IDX_W-1:0]   best_idx;
    logic [15:0]        id;
    logic signed [15:0] rssi;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic               has_pos;
  } carry_t;

  typedef struct packed {
    mode_t              mode;
    logic [15:0]        key;
    logic [CNT_W-1:0]   used;
    logic [IDX_W-1:0]   sort_i;
    logic               init;
    logic               wr;
    logic [IDX_W-1:0]   wr_idx;
    logic               clear;
    cmd_t               wcmd;
    logic signed [15:0] rssi;
    logic [31:0]        ts;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic               swap;
    logic [IDX_W-1:0]   win_idx;
    logic [IDX_W-1:0]   win_pos;
  } ctrl_t;

endpackage

>>> sv/node_table_lru_eviction_core.sv
// Node table of 16 entries keyed by id, held in a row of cells. A heard or
// set-position request makes one pass of a token along the 16 cells to find
// the id and the least recently heard entry, then the entry is written. A
// snapshot request with n entries to return makes one cell pass per entry
// and gives one result at the end of each pass; a snapshot with nothing to
// return gives its single invalid result in the cycle after the request and
// leaves busy low. Results appear on strobe for one cycle each and must be
// taken then.
module node_table_lru_eviction_core import ntl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic [15:0]        node_id,
  input  logic signed [15:0] rssi,
  input  logic [31:0]        timestamp,
  input  logic signed [30:0] latitude,
  input  logic signed [31:0] longitude,
  input  logic [4:0]         max_entries,
  output logic               strobe,
  output logic [15:0]        entry_id,
  output logic [31:0]        last_heard,
  output logic signed [15:0] entry_rssi,
  output logic signed [30:0] entry_latitude,
  output logic signed [31:0] entry_longitude,
  output logic               has_position,
  output logic               entry_valid,
  output logic [4:0]         returned_count,
  output logic               last_of_run
);

  state_t state, state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] used_count;
  logic [IDX_W-1:0] sort_i;
  logic [CNT_W-1:0] sort_n;
  logic [CNT_W-1:0] snap_n;
  logic [4:0]       lim;

  cmd_t               req_cmd;
  logic [15:0]        req_key;
  logic signed [15:0] req_rssi;
  logic [31:0]        req_ts;
  logic signed [30:0] req_lat;
  logic signed [31:0] req_lon;

  ctrl_t  ctrl;
  carry_t chain [DEPTH+1];
  logic   accept;
  logic   pass_done;
  logic   full;
  logic   last_pick;

  assign accept    = start && !busy;
  assign pass_done = (cnt == CNT_W'(DEPTH));
  assign full      = (used_count == CNT_W'(DEPTH));
  assign last_pick = ({1'b0, sort_i} + 1'b1) == sort_n;
  assign lim       = (max_entries > 5'(MAX_OUT)) ? 5'(MAX_OUT) : max_entries;
  assign snap_n    = (used_count < CNT_W'(lim)) ? used_count : CNT_W'(lim);
  assign chain[0]  = '0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    ntl_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(k)),
      .ctrl      (ctrl),
      .carry_in  (chain[k]),
      .carry_out (chain[k+1])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && command == CMD_SNAP && snap_n != '0) begin
          state_next = ST_SORT;
        end else if (accept && (command == CMD_HEARD || command == CMD_POS)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: if (pass_done) state_next = ST_IDLE;
      ST_SORT: if (pass_done && last_pick) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state != ST_IDLE);
    ctrl         = '0;
    ctrl.mode    = (state == ST_SORT) ? MODE_SORT : MODE_LOOKUP;
    ctrl.key     = req_key;
    ctrl.used    = used_count;
    ctrl.sort_i  = sort_i;
    ctrl.wcmd    = req_cmd;
    ctrl.rssi    = req_rssi;
    ctrl.ts      = req_ts;
    ctrl.lat     = req_lat;
    ctrl.lon     = req_lon;
    ctrl.win_idx = chain[DEPTH].best_idx;
    ctrl.win_pos = chain[DEPTH].best_pos;
    case (state)
      ST_IDLE: ctrl.init = accept && command == CMD_SNAP;
      ST_SCAN: begin
        ctrl.wr = pass_done;
        if (chain[DEPTH].hit) begin
          ctrl.wr_idx = chain[DEPTH].hit_idx;
        end else begin
          ctrl.clear  = 1'b1;
          ctrl.wr_idx = full ? chain[DEPTH].best_idx : used_count[IDX_W-1:0];
        end
      end
      ST_SORT: ctrl.swap = pass_done;
      default: ctrl.wr = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      used_count <= '0;
      strobe     <= 1'b0;
      cnt        <= '0;
    end else begin
      state  <= state_next;
      strobe <= (state == ST_IDLE && accept && command == CMD_SNAP && snap_n == '0) ||
                (state == ST_SORT && pass_done);
      if (state == ST_IDLE) begin
        cnt <= '0;
      end else if (pass_done) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
      if (state == ST_SCAN && pass_done && !chain[DEPTH].hit && !full) begin
        used_count <= used_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd  <= cmd_t'(command);
      req_key  <= node_id;
      req_rssi <= rssi;
      req_ts   <= timestamp;
      req_lat  <= latitude;
      req_lon  <= longitude;
      sort_n   <= snap_n;
      sort_i   <= '0;
      entry_id        <= '0;
      last_heard      <= '0;
      entry_rssi      <= '0;
      entry_latitude  <= '0;
      entry_longitude <= '0;
      has_position    <= 1'b0;
      entry_valid     <= 1'b0;
      returned_count  <= '0;
      last_of_run     <= 1'b1;
    end
    if (state == ST_SORT && pass_done) begin
      entry_id        <= chain[DEPTH].id;
      last_heard      <= chain[DEPTH].best_time;
      entry_rssi      <= chain[DEPTH].rssi;
      entry_latitude  <= chain[DEPTH].lat;
      entry_longitude <= chain[DEPTH].lon;
      has_position    <= chain[DEPTH].has_pos;
      entry_valid     <= 1'b1;
      returned_count  <= 5'(sort_n);
      last_of_run     <= last_pick;
      sort_i          <= sort_i + 1'b1;
    end
  end

  a_sort_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SORT |-> ({1'b0, sort_i} < sort_n))
    else $error("sort index beyond count");

  a_sort_has_pick: assert property (@(posedge clk) disable iff (rst)
    state == ST_SORT && pass_done |-> chain[DEPTH].best_ok)
    else $error("sort pass found no entry");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CNT_W'(DEPTH))
    else $error("used count overflow");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !entry_valid |-> last_of_run && returned_count == '0)
    else $error("empty snapshot result malformed");

endmodule

>>> sv/ntl_cell.sv
module ntl_cell import ntl_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  ctrl_t            ctrl,
  input  carry_t           carry_in,
  output carry_t           carry_out
);

  logic [15:0]        id;
  logic [31:0]        time_q;
  logic signed [15:0] rssi;
  logic signed [30:0] lat;
  logic signed [31:0] lon;
  logic               has_pos;
  logic [IDX_W-1:0]   pos;

  carry_t carry_next;
  logic   live;
  logic   take;

  always_comb begin
    carry_next = carry_in;
    take = 1'b0;
    live = ({1'b0, idx} < ctrl.used);
    if (ctrl.mode == MODE_LOOKUP) begin
      if (!carry_in.hit && live && id == ctrl.key) begin
        carry_next.hit     = 1'b1;
        carry_next.hit_idx = idx;
      end
      take = !carry_in.best_ok || time_q < carry_in.best_time;
    end else begin
      take = live && pos >= ctrl.sort_i &&
             (!carry_in.best_ok || time_q > carry_in.best_time ||
              (time_q == carry_in.best_time && pos < carry_in.best_pos));
    end
    if (take) begin
      carry_next.best_ok   = 1'b1;
      carry_next.best_time = time_q;
      carry_next.best_pos  = pos;
      carry_next.best_idx  = idx;
      carry_next.id        = id;
      carry_next.rssi      = rssi;
      carry_next.lat       = lat;
      carry_next.lon       = lon;
      carry_next.has_pos   = has_pos;
    end
  end

  always_ff @(posedge clk) begin
    carry_out <= carry_next;
    if (ctrl.wr && ctrl.wr_idx == idx) begin
      id <= ctrl.key;
      if (ctrl.wcmd == CMD_HEARD) begin
        time_q <= ctrl.ts;
        rssi   <= ctrl.rssi;
        if (ctrl.clear) begin
          lat     <= '0;
          lon     <= '0;
          has_pos <= 1'b0;
        end
      end else begin
        lat     <= ctrl.lat;
        lon     <= ctrl.lon;
        has_pos <= 1'b1;
        if (ctrl.clear) begin
          time_q <= '0;
          rssi   <= '0;
        end
      end
    end
    if (ctrl.init) begin
      pos <= idx;
    end else if (ctrl.swap) begin
      if (idx == ctrl.win_idx) begin
        pos <= ctrl.sort_i;
      end else if (pos == ctrl.sort_i) begin
        pos <= ctrl.win_pos;
      end
    end
  end

endmodule

>>> tb/tb_node_table_lru_eviction_core.sv
module tb_node_table_lru_eviction_core import ntl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    logic [1:0]         cmd;
    logic [15:0]        id;
    logic signed [15:0] rssi;
    logic [31:0]        ts;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic [4:0]         max_n;
    bit                 drain_first;
  } request_t;

  typedef struct {
    logic [15:0]        id;
    logic [31:0]        heard;
    logic signed [15:0] rssi;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic               has_pos;
    logic               valid;
    logic [4:0]         count;
    logic               last;
  } entry_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         command = '0;
  logic [15:0]        node_id = '0;
  logic signed [15:0] rssi = '0;
  logic [31:0]        timestamp = '0;
  logic signed [30:0] latitude = '0;
  logic signed [31:0] longitude = '0;
  logic [4:0]         max_entries = '0;
  logic               strobe;
  logic [15:0]        entry_id;
  logic [31:0]        last_heard;
  logic signed [15:0] entry_rssi;
  logic signed [30:0] entry_latitude;
  logic signed [31:0] entry_longitude;
  logic               has_position;
  logic               entry_valid;
  logic [4:0]         returned_count;
  logic               last_of_run;

  node_table_lru_eviction_core dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // shadow copy of the node table
  logic [15:0]        node_ids   [DEPTH];
  logic [31:0]        node_times [DEPTH];
  logic signed [15:0] node_rssi  [DEPTH];
  logic signed [30:0] node_lat   [DEPTH];
  logic signed [31:0] node_lon   [DEPTH];
  logic               node_pos   [DEPTH];
  int                 nodes_used = 0;

  request_t pending_requests[$];
  entry_t   snapshot_entries[$];
  request_t cur;
  int  mismatches = 0;
  int  results_seen = 0;
  int  accepted = 0;
  int  snapshots = 0;
  int  evictions = 0;
  int  cycles = 0;
  int  gap_left = 0;
  int  burst_left = 0;

  function automatic int find_or_take(input logic [15:0] key);
    int slot;
    for (int i = 0; i < nodes_used; i++)
      if (node_ids[i] == key) return i;
    if (nodes_used < DEPTH) begin
      slot = nodes_used;
      nodes_used++;
    end else begin
      slot = 0;
      for (int i = 1; i < DEPTH; i++)
        if (node_times[i] < node_times[slot]) slot = i;
      evictions++;
    end
    node_ids[slot] = key;
    node_times[slot] = '0;
    node_rssi[slot] = '0;
    node_lat[slot] = '0;
    node_lon[slot] = '0;
    node_pos[slot] = 1'b0;
    return slot;
  endfunction

  function automatic void apply_request(input request_t r);
    int slot, n, lim, best, tmp;
    int order[DEPTH];
    entry_t e;
    case (r.cmd)
      CMD_HEARD: begin
        slot = find_or_take(r.id);
        node_times[slot] = r.ts;
        node_rssi[slot] = r.rssi;
      end
      CMD_POS: begin
        slot = find_or_take(r.id);
        node_lat[slot] = r.lat;
        node_lon[slot] = r.lon;
        node_pos[slot] = 1'b1;
      end
      CMD_SNAP: begin
        snapshots++;
        lim = (r.max_n > MAX_OUT) ? MAX_OUT : int'(r.max_n);
        n = (nodes_used < lim) ? nodes_used : lim;
        if (n == 0) begin
          e = '{default: '0};
          e.last = 1'b1;
          snapshot_entries.push_back(e);
        end else begin
          for (int i = 0; i < nodes_used; i++) order[i] = i;
          for (int i = 0; i < n; i++) begin
            best = i;
            for (int j = i + 1; j < nodes_used; j++)
              if (node_times[order[j]] > node_times[order[best]]) best = j;
            tmp = order[i];
            order[i] = order[best];
            order[best] = tmp;
            e.id = node_ids[order[i]];
            e.heard = node_times[order[i]];
            e.rssi = node_rssi[order[i]];
            e.lat = node_lat[order[i]];
            e.lon = node_lon[order[i]];
            e.has_pos = node_pos[order[i]];
            e.valid = 1'b1;
            e.count = n[4:0];
            e.last = (i + 1 == n);
            snapshot_entries.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_request(cur);
        accepted++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_requests.size() == 0 ||
                     (pending_requests[0].drain_first &&
                      (snapshot_entries.size() != 0 || busy || start))) begin
          start <= 1'b0;
        end else begin
          cur = pending_requests.pop_front();
          command <= cur.cmd;
          node_id <= cur.id;
          rssi <= cur.rssi;
          timestamp <= cur.ts;
          latitude <= cur.lat;
          longitude <= cur.lon;
          max_entries <= cur.max_n;
          start <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = int'($urandom_range(1, 12));
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
          end
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    entry_t e;
    if (!rst && strobe) begin
      results_seen++;
      if (snapshot_entries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: id %h heard %h", entry_id, last_heard);
      end else begin
        e = snapshot_entries.pop_front();
        if (entry_id !== e.id || last_heard !== e.heard || entry_rssi !== e.rssi ||
            entry_latitude !== e.lat || entry_longitude !== e.lon ||
            has_position !== e.has_pos || entry_valid !== e.valid ||
            returned_count !== e.count || last_of_run !== e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp id %h heard %h rssi %0d lat %0d lon %0d",
                     e.id, e.heard, e.rssi, e.lat, e.lon);
            $display("          exp pos %b v %b n %0d l %b",
                     e.has_pos, e.valid, e.count, e.last);
            $display("          got id %h heard %h rssi %0d lat %0d lon %0d",
                     entry_id, last_heard, entry_rssi, entry_latitude, entry_longitude);
            $display("          got pos %b v %b n %0d l %b",
                     has_position, entry_valid, returned_count, last_of_run);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** node_table_lru_eviction_core: FAILED **");
      $finish;
    end
  end

  function automatic request_t make_request(input logic [1:0] cmd, input logic [15:0] id,
                                            input logic [31:0] ts, input logic [4:0] max_n);
    request_t r;
    r.cmd = cmd;
    r.id = id;
    r.ts = ts;
    r.max_n = max_n;
    r.rssi = 16'($urandom);
    r.lat = 31'($signed($urandom_range(0, 1800000000)) - 900000000);
    r.lon = 32'($signed($urandom_range(0, 32'd3600000000)) - 32'sd1800000000);
    r.drain_first = 1'b0;
    return r;
  endfunction

  initial begin
    request_t r;
    logic [15:0] id_pool[24];
    logic [31:0] clock_ms;
    int pick;

    // directed: empty table, field extremes, unused code, large limits
    pending_requests.push_back(make_request(CMD_SNAP, 16'h0000, '0, 5'd0));
    pending_requests.push_back(make_request(CMD_SNAP, 16'h0000, '0, 5'd31));
    r = make_request(CMD_HEARD, 16'h0000, 32'h0, 5'd0);
    r.rssi = 16'sh7fff;
    pending_requests.push_back(r);
    r = make_request(CMD_HEARD, 16'hffff, 32'hffffffff, 5'd0);
    r.rssi = 16'sh8000;
    pending_requests.push_back(r);
    r = make_request(CMD_POS, 16'hffff, '0, 5'd0);
    r.lat = 31'sd900000000;
    r.lon = 32'sd1800000000;
    pending_requests.push_back(r);
    r = make_request(CMD_POS, 16'h1234, '0, 5'd0);
    r.lat = -31'sd900000000;
    r.lon = -32'sd1800000000;
    pending_requests.push_back(r);
    pending_requests.push_back(make_request(CMD_UNUSED, 16'h0000, 32'h0, 5'd31));
    pending_requests.push_back(make_request(CMD_SNAP, 16'h0000, '0, 5'd1));
    pending_requests.push_back(make_request(CMD_SNAP, 16'h0000, '0, 5'd16));
    pending_requests.push_back(make_request(CMD_SNAP, 16'h0000, '0, 5'd0));
    for (int i = 0; i < 15; i++)
      pending_requests.push_back(make_request(CMD_HEARD, 16'(16'h0100 + i), 32'd7, 5'd0));
    pending_requests.push_back(make_request(CMD_SNAP, 16'h0000, '0, 5'd31));

    // random: a pool of ids so that hits, fills and evictions all occur
    for (int i = 0; i < 24; i++) id_pool[i] = 16'($urandom);
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hffff;
    clock_ms = $urandom_range(0, 1000);
    for (int k = 0; k < 420; k++) begin
      pick = int'($urandom_range(0, 99));
      case ($urandom_range(0, 3))
        0: clock_ms = $urandom;
        1: ;
        default: clock_ms = clock_ms + $urandom_range(1, 50);
      endcase
      if (pick < 12)
        r = make_request(CMD_SNAP, 16'($urandom), $urandom, 5'($urandom_range(0, 31)));
      else if (pick < 14)
        r = make_request(CMD_UNUSED, 16'($urandom), $urandom, 5'($urandom));
      else if (pick < 40)
        r = make_request(CMD_POS, id_pool[$urandom_range(0, 23)], $urandom, 5'($urandom));
      else if (pick < 95)
        r = make_request(CMD_HEARD, id_pool[$urandom_range(0, 23)], clock_ms, 5'($urandom));
      else
        r = make_request(CMD_HEARD, 16'($urandom), clock_ms, 5'($urandom));
      if (k % 60 == 30) r.drain_first = 1'b1;
      pending_requests.push_back(r);
    end

    wait (!rst);
    wait (pending_requests.size() == 0);
    @(posedge clk);
    while (start || snapshot_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d requests accepted, %0d snapshots, %0d results checked, %0d evictions",
             accepted, snapshots, results_seen, evictions);
    if (snapshot_entries.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("** node_table_lru_eviction_core: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** node_table_lru_eviction_core: FAILED **");
    end
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

endmodule

>>> files.f
sv/ntl_pkg.sv
sv/ntl_cell.sv
sv/node_table_lru_eviction_core.sv
tb/tb_node_table_lru_eviction_core.sv
